// File: rtl/bhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhp_pkg
// shared types, command and status codes, and header byte positions for the
// bmp header parser and pixel address generator
// ----------------------------------------------------------------------------
package bhp_pkg;

    localparam int DIM_BITS_DEF = 16;
    localparam int ADDR_W       = 32;
    localparam int ROW_BYTES_W  = 18;
    localparam int PX_TERM_W    = 18;

    // commands
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // header status codes
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_SIG     = 3'd2;
    localparam logic [2:0] ST_PLANES  = 3'd3;
    localparam logic [2:0] ST_DEPTH   = 3'd4;
    localparam logic [2:0] ST_COMP    = 3'd5;
    localparam logic [2:0] ST_BIG     = 3'd6;

    localparam logic [15:0] BMP_SIG  = 16'h4D42;
    localparam logic [15:0] PLANES_1 = 16'd1;
    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;
    localparam logic [2:0]  PB_24    = 3'd3;
    localparam logic [2:0]  PB_32    = 3'd4;

    // header length and last byte position of each header field
    localparam logic [5:0] HDR_LEN        = 6'd34;
    localparam logic [5:0] POS_SIG_END    = 6'd1;
    localparam logic [5:0] POS_OFFSET_END = 6'd13;
    localparam logic [5:0] POS_WIDTH_END  = 6'd21;
    localparam logic [5:0] POS_HEIGHT_END = 6'd25;
    localparam logic [5:0] POS_PLANES_END = 6'd27;
    localparam logic [5:0] POS_DEPTH_END  = 6'd29;
    localparam logic [5:0] POS_COMP_END   = 6'd33;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  header_byte;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } item_t;

    typedef struct packed {
        logic [2:0]             header_status;
        logic [ADDR_W-1:0]      pixel_address;
        logic                   address_valid;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic                   right_side_up;
    } result_t;

    // header state as reported after one word
    typedef struct packed {
        logic [2:0]             status;
        logic                   upright;
        logic [ROW_BYTES_W-1:0] row_bytes;
    } hdr_report_t;

    // header state seen by the address path
    typedef struct packed {
        logic              accepted;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] height;
        logic              upright;
        logic [2:0]        pixel_bytes;
        logic [ADDR_W-1:0] stride;
    } hdr_view_t;

endpackage
`default_nettype wire

// File: rtl/bhp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhp_parser
// header byte assembler, field checks and captured image geometry
// ----------------------------------------------------------------------------
module bhp_parser #(
    parameter int DIM_BITS = bhp_pkg::DIM_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire bhp_pkg::item_t      item,
    output bhp_pkg::hdr_report_t     hdr_next,
    output bhp_pkg::hdr_view_t       hdr_view
);

    localparam int STRIDE_W = DIM_BITS + 2;

    logic [5:0]          byte_count_reg,   byte_count_next;
    logic [31:0]         field_shift_reg,  field_shift_next;
    logic [31:0]         image_offset_reg, image_offset_next;
    logic [DIM_BITS-1:0] image_width_reg,  image_width_next;
    logic [DIM_BITS-1:0] image_height_reg, image_height_next;
    logic                upright_reg,      upright_next;
    logic [2:0]          pixel_bytes_reg,  pixel_bytes_next;
    logic [STRIDE_W-1:0] row_stride_reg,   row_stride_next;
    logic [2:0]          parse_status_reg, parse_status_next;

    logic [31:0]         shifted;
    logic [15:0]         w16;
    logic [31:0]         mag;
    logic [STRIDE_W-1:0] width_x_pb;
    logic [STRIDE_W-1:0] stride_calc;

    assign shifted     = {item.header_byte, field_shift_reg[31:8]};
    assign w16         = shifted[31:16];
    assign mag         = shifted[31] ? (~shifted + 32'd1) : shifted;
    assign width_x_pb  = STRIDE_W'(image_width_reg) * STRIDE_W'(pixel_bytes_reg);
    assign stride_calc = (width_x_pb + STRIDE_W'(3)) & ~STRIDE_W'(3);

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        field_shift_next  = field_shift_reg;
        image_offset_next = image_offset_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        upright_next      = upright_reg;
        pixel_bytes_next  = pixel_bytes_reg;
        row_stride_next   = row_stride_reg;
        parse_status_next = parse_status_reg;
        if (take)
        begin
            unique case (item.cmd)
                bhp_pkg::CMD_RESTART:
                begin
                    byte_count_next   = '0;
                    field_shift_next  = '0;
                    image_offset_next = '0;
                    image_width_next  = '0;
                    image_height_next = '0;
                    upright_next      = 1'b0;
                    pixel_bytes_next  = '0;
                    row_stride_next   = '0;
                    parse_status_next = bhp_pkg::ST_PENDING;
                end
                bhp_pkg::CMD_BYTE:
                begin
                    if (parse_status_reg == bhp_pkg::ST_PENDING &&
                        byte_count_reg < bhp_pkg::HDR_LEN)
                    begin
                        field_shift_next = shifted;
                        byte_count_next  = byte_count_reg + 6'd1;
                        unique case (byte_count_reg)
                            bhp_pkg::POS_SIG_END:
                            begin
                                if (w16 != bhp_pkg::BMP_SIG)
                                    parse_status_next = bhp_pkg::ST_SIG;
                            end
                            bhp_pkg::POS_OFFSET_END:
                            begin
                                image_offset_next = shifted;
                            end
                            bhp_pkg::POS_WIDTH_END:
                            begin
                                if (|shifted[31:DIM_BITS])
                                    parse_status_next = bhp_pkg::ST_BIG;
                                else
                                    image_width_next = shifted[DIM_BITS-1:0];
                            end
                            bhp_pkg::POS_HEIGHT_END:
                            begin
                                upright_next = shifted[31];
                                if (|mag[31:DIM_BITS])
                                    parse_status_next = bhp_pkg::ST_BIG;
                                else
                                    image_height_next = mag[DIM_BITS-1:0];
                            end
                            bhp_pkg::POS_PLANES_END:
                            begin
                                if (w16 != bhp_pkg::PLANES_1)
                                    parse_status_next = bhp_pkg::ST_PLANES;
                            end
                            bhp_pkg::POS_DEPTH_END:
                            begin
                                if (w16 == bhp_pkg::DEPTH_24)
                                    pixel_bytes_next = bhp_pkg::PB_24;
                                else if (w16 == bhp_pkg::DEPTH_32)
                                    pixel_bytes_next = bhp_pkg::PB_32;
                                else
                                    parse_status_next = bhp_pkg::ST_DEPTH;
                            end
                            bhp_pkg::POS_COMP_END:
                            begin
                                if (shifted != 32'd0)
                                    parse_status_next = bhp_pkg::ST_COMP;
                                else
                                begin
                                    row_stride_next   = stride_calc;
                                    parse_status_next = bhp_pkg::ST_OK;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                bhp_pkg::CMD_QUERY, bhp_pkg::CMD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            field_shift_reg  <= '0;
            image_offset_reg <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            upright_reg      <= 1'b0;
            pixel_bytes_reg  <= '0;
            row_stride_reg   <= '0;
            parse_status_reg <= bhp_pkg::ST_PENDING;
        end
        else
        begin
            byte_count_reg   <= byte_count_next;
            field_shift_reg  <= field_shift_next;
            image_offset_reg <= image_offset_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            upright_reg      <= upright_next;
            pixel_bytes_reg  <= pixel_bytes_next;
            row_stride_reg   <= row_stride_next;
            parse_status_reg <= parse_status_next;
        end
    end

    assign hdr_next.status    = parse_status_next;
    assign hdr_next.upright   = upright_next;
    assign hdr_next.row_bytes = bhp_pkg::ROW_BYTES_W'(row_stride_next);

    assign hdr_view.accepted    = (parse_status_reg == bhp_pkg::ST_OK);
    assign hdr_view.offset      = image_offset_reg;
    assign hdr_view.height      = bhp_pkg::ADDR_W'(image_height_reg);
    assign hdr_view.upright     = upright_reg;
    assign hdr_view.pixel_bytes = pixel_bytes_reg;
    assign hdr_view.stride      = bhp_pkg::ADDR_W'(row_stride_reg);

endmodule
`default_nettype wire

// File: rtl/bhp_addr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhp_addr
// two stage pixel address path: row times stride, then the three term sum
// ----------------------------------------------------------------------------
module bhp_addr (
    input  wire logic                      clk,
    input  wire logic                      s1_en,
    input  wire logic                      s2_en,
    input  wire bhp_pkg::item_t            item,
    input  wire bhp_pkg::hdr_view_t        hdr_view,
    output logic [bhp_pkg::ADDR_W-1:0]     pixel_address,
    output logic                           address_valid
);

    localparam int AW = bhp_pkg::ADDR_W;
    localparam int PW = bhp_pkg::PX_TERM_W;

    logic          query;
    logic [AW-1:0] row;
    logic [AW-1:0] row_prod;
    logic [PW-1:0] px_term;

    logic          valid_s1_reg;
    logic [AW-1:0] prod_s1_reg;
    logic [AW-1:0] base_s1_reg;
    logic [PW-1:0] px_s1_reg;
    logic [AW-1:0] addr_reg;
    logic          valid_reg;

    assign query    = (item.cmd == bhp_pkg::CMD_QUERY) && hdr_view.accepted;
    // bottom-up images count rows from the last stored row
    assign row      = hdr_view.upright ? AW'(item.pixel_y)
                                       : hdr_view.height - AW'(item.pixel_y) - AW'(1);
    assign row_prod = row * hdr_view.stride;
    assign px_term  = (hdr_view.pixel_bytes == bhp_pkg::PB_32)
                    ? {item.pixel_x, 2'b00}
                    : PW'({item.pixel_x, 1'b0}) + PW'(item.pixel_x);

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            valid_s1_reg <= query;
            prod_s1_reg  <= row_prod;
            base_s1_reg  <= hdr_view.offset;
            px_s1_reg    <= px_term;
        end
        if (s2_en)
        begin
            valid_reg <= valid_s1_reg;
            addr_reg  <= valid_s1_reg ? base_s1_reg + prod_s1_reg + AW'(px_s1_reg) : '0;
        end
    end

    assign pixel_address = addr_reg;
    assign address_valid = valid_reg;

endmodule
`default_nettype wire

// File: rtl/bmp_header_parse_pixel_address.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_header_parse_pixel_address
// bmp header parser with pixel byte address generation
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word, in order. A word is taken
// each cycle while the result side keeps up, so the sustained rate is one
// word per clock. A taken word is held in the input register; as it leaves,
// header state is updated and the 32 x 32 row times stride product is formed
// into the product register, and the final offset + product + column term
// sum then goes into the result register. Stall from the result side ripples
// back through the three stages, and an empty stage is always refilled, so
// a held result never blocks a bubble further upstream. Header bytes come in
// little-endian, 34 per header; status stays pending until a check fails or
// the compression word passes, and the first failing check sticks until a
// restart word.
// ----------------------------------------------------------------------------
module bmp_header_parse_pixel_address #(
    parameter int DIM_BITS = bhp_pkg::DIM_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input words
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire bhp_pkg::item_t    item,
    // result words
    output logic                   result_valid,
    input  wire logic              result_stall,
    output bhp_pkg::result_t       result
);

    // pipeline occupancy
    logic                 s0_valid_reg;
    bhp_pkg::item_t       s0_item_reg;
    logic                 s1_valid_reg;
    bhp_pkg::hdr_report_t s1_hdr_reg;
    logic                 result_valid_reg;
    bhp_pkg::hdr_report_t out_hdr_reg;

    logic                 out_ready;
    logic                 s1_ready;
    logic                 s0_ready;
    logic                 s1_en;
    logic                 s2_en;

    bhp_pkg::hdr_report_t hdr_next;
    bhp_pkg::hdr_view_t   hdr_view;
    logic [bhp_pkg::ADDR_W-1:0] pixel_address;
    logic                 address_valid;

    // a stage can load when empty or when its word moves on this cycle
    assign out_ready  = !result_valid_reg || !result_stall;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign s0_ready   = !s0_valid_reg || s1_ready;
    assign s1_en      = s0_valid_reg && s1_ready;
    assign s2_en      = s1_valid_reg && out_ready;
    assign item_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
                s0_valid_reg <= item_valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
            if (out_ready)
                result_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s0_ready && item_valid)
            s0_item_reg <= item;
        if (s1_en)
            s1_hdr_reg <= hdr_next;
        if (s2_en)
            out_hdr_reg <= s1_hdr_reg;
    end

    // header state advances as a word leaves the input register, so a query
    // always sees every header byte taken before it
    bhp_parser #(
        .DIM_BITS (DIM_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (s1_en),
        .item     (s0_item_reg),
        .hdr_next (hdr_next),
        .hdr_view (hdr_view)
    );

    bhp_addr u_addr (
        .clk           (clk),
        .s1_en         (s1_en),
        .s2_en         (s2_en),
        .item          (s0_item_reg),
        .hdr_view      (hdr_view),
        .pixel_address (pixel_address),
        .address_valid (address_valid)
    );

    assign result_valid         = result_valid_reg;
    assign result.header_status = out_hdr_reg.status;
    assign result.pixel_address = pixel_address;
    assign result.address_valid = address_valid;
    assign result.row_bytes     = out_hdr_reg.row_bytes;
    assign result.right_side_up = out_hdr_reg.upright;

endmodule
`default_nettype wire

// File: rtl/bhp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bhp_checker
// port level checks on result words of the bmp header parser
// ----------------------------------------------------------------------------
module bhp_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire bhp_pkg::result_t result
);

    // held result word keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // an address is only answered for an accepted header
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.address_valid |-> result.header_status == bhp_pkg::ST_OK)
        else $error("address answered without accepted header");

    // unanswered query reads as zero
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.address_valid |-> result.pixel_address == '0)
        else $error("nonzero address without address_valid");

    // padded stride is a multiple of four
    a_row_pad: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.row_bytes[1:0] == 2'b00)
        else $error("row stride not padded to four bytes");

endmodule

bind bmp_header_parse_pixel_address bhp_checker u_bhp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
